// ===== hw/rtl/touch_key_event_decoder_macros.svh =====
// Assertion macros for the checker file of the touch key event decoder.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef TOUCH_KEY_EVENT_DECODER_MACROS_SVH
`define TOUCH_KEY_EVENT_DECODER_MACROS_SVH

// Same-cycle implication.
`define TKED_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("touch key decoder check failed");

// Next-cycle implication.
`define TKED_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("touch key decoder check failed");

`endif

// ===== hw/rtl/tked_pkg.sv =====
// Shared types and constants of the touch key event decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tked_pkg;

	localparam int NUM_KEYS  = 6;
	localparam int TIME_W    = 32;
	localparam int THR_W     = 16;
	localparam int CNT_W     = $clog2(NUM_KEYS + 1);

	localparam logic [NUM_KEYS-1:0] EVEN_PATTERN = 6'h15;
	localparam logic [NUM_KEYS-1:0] ODD_PATTERN  = 6'h2a;
	localparam logic [CNT_W-1:0]    MULTI_MIN    = 3'd4;

	localparam logic [THR_W-1:0] LONG_TOUCH_RST   = 16'd1000;
	localparam logic [THR_W-1:0] GESTURE_HOLD_RST = 16'd2000;

	typedef enum logic [0:0] {
		CFG_LONG_TOUCH   = 1'b0,
		CFG_GESTURE_HOLD = 1'b1
	} cfg_idx_t;

	// Per-key outcome of one sample
	typedef struct packed {
		logic begin_ev;
		logic release_ev;
		logic holding;
		logic long_event;
		logic long_held;
	} key_evt_t;

	function automatic logic [CNT_W-1:0] count_keys(input logic [NUM_KEYS-1:0] m);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			n = n + CNT_W'(m[i]);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tked_key_unit.sv =====
// Per-key touch tracker: begin/release/holding and one-shot long touch.
// Depends on tked_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tked_key_unit
	import tked_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              cur,
	input  wire logic [TIME_W-1:0] now,
	input  wire logic [THR_W-1:0]  long_thr,
	output key_evt_t               evt
);

	logic              prev_q;
	logic              armed_q;
	logic              long_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] elapsed;
	logic              both;
	logic              fire;

	assign elapsed = now - start_q;
	assign both    = cur & prev_q;
	// start_q is only looked at while armed, and arming always writes it
	assign fire    = both & armed_q & (elapsed >= {{(TIME_W-THR_W){1'b0}}, long_thr});

	always_comb begin
		evt.begin_ev   = cur & ~prev_q;
		evt.release_ev = ~cur & prev_q;
		evt.holding    = both & ~fire;
		evt.long_event = fire;
		evt.long_held  = (long_q | fire) & cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			armed_q <= 1'b0;
			long_q  <= 1'b0;
		end else if (en) begin
			prev_q <= cur;
			long_q <= evt.long_held;
			if (evt.begin_ev) begin
				armed_q <= 1'b1;
			end else if (fire) begin
				armed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && evt.begin_ev) begin
			start_q <= now;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tked_gesture_timer.sv =====
// Hold timer for one multi-key gesture, compared against the gesture threshold.
// Depends on tked_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tked_gesture_timer
	import tked_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              active,
	input  wire logic [TIME_W-1:0] now,
	input  wire logic [THR_W-1:0]  hold_thr,
	output logic                   held
);

	logic              run_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] elapsed;

	// first active sample counts as zero elapsed
	assign elapsed = run_q ? (now - start_q) : '0;
	assign held    = active & (elapsed >= {{(TIME_W-THR_W){1'b0}}, hold_thr});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (en) begin
			run_q <= active;
		end
	end

	always_ff @(posedge clk) begin
		if (en && active && !run_q) begin
			start_q <= now;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/touch_key_event_decoder.sv =====
// Touch key event decoder, top level.
// Path: a sample goes through the input register, then the result register, before its result beat is offered.
// Throughput: one sample per cycle while out_ready is high; each key and gesture timer is one 32-bit subtract/compare.
// Reset (arst_n low): key history, timers and sleep flag cleared, thresholds to 1000/2000 ms.
// Start-time registers are not reset; they are read only after being written.
// Depends on tked_pkg, tked_key_unit, tked_gesture_timer.
`timescale 1ns / 1ps
`default_nettype none

module touch_key_event_decoder
	import tked_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [THR_W-1:0]    cfg_data,

	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [NUM_KEYS-1:0] key_mask,
	input  wire logic [TIME_W-1:0]   now_ms,

	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [NUM_KEYS-1:0]      begin_mask,
	output logic [NUM_KEYS-1:0]      release_mask,
	output logic [NUM_KEYS-1:0]      holding_mask,
	output logic [NUM_KEYS-1:0]      long_event_mask,
	output logic [NUM_KEYS-1:0]      long_held_mask,
	output logic                     three_key_hold,
	output logic                     four_key_hold,
	output logic                     sleep_request
);

	logic [THR_W-1:0]    long_thr_q;
	logic [THR_W-1:0]    gesture_thr_q;

	logic                valid_s1;
	logic [NUM_KEYS-1:0] keys_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                adv;

	key_evt_t            evt [NUM_KEYS];
	logic [NUM_KEYS-1:0] begin_d, release_d, holding_d, long_ev_d, long_held_d;
	logic                even_hold, odd_hold, multi_hold, three_d;
	logic                sleep_sent_q;

	logic                valid_s2;
	logic [NUM_KEYS-1:0] begin_s2, release_s2, holding_s2, long_ev_s2, long_held_s2;
	logic                three_s2, four_s2, sleep_s2;

	// ---- configuration ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_thr_q    <= LONG_TOUCH_RST;
			gesture_thr_q <= GESTURE_HOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LONG_TOUCH:   long_thr_q    <= cfg_data;
				CFG_GESTURE_HOLD: gesture_thr_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// ---- input register ----
	assign adv      = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			keys_s1 <= key_mask;
			now_s1  <= now_ms;
		end
	end

	// ---- per-key decisions; state moves only when the beat advances ----
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		tked_key_unit u_key (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.cur      (keys_s1[k]),
			.now      (now_s1),
			.long_thr (long_thr_q),
			.evt      (evt[k])
		);

		assign begin_d[k]     = evt[k].begin_ev;
		assign release_d[k]   = evt[k].release_ev;
		assign holding_d[k]   = evt[k].holding;
		assign long_ev_d[k]   = evt[k].long_event;
		assign long_held_d[k] = evt[k].long_held;
	end

	// ---- gesture timers ----
	tked_gesture_timer u_even (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.active   (keys_s1 == EVEN_PATTERN),
		.now      (now_s1),
		.hold_thr (gesture_thr_q),
		.held     (even_hold)
	);

	tked_gesture_timer u_odd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.active   (keys_s1 == ODD_PATTERN),
		.now      (now_s1),
		.hold_thr (gesture_thr_q),
		.held     (odd_hold)
	);

	tked_gesture_timer u_multi (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.active   (count_keys(keys_s1) >= MULTI_MIN),
		.now      (now_s1),
		.hold_thr (gesture_thr_q),
		.held     (multi_hold)
	);

	assign three_d = even_hold | odd_hold;

	// sleep request fires once per continuous three-key hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_sent_q <= 1'b0;
		end else if (adv) begin
			sleep_sent_q <= three_d;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			begin_s2     <= begin_d;
			release_s2   <= release_d;
			holding_s2   <= holding_d;
			long_ev_s2   <= long_ev_d;
			long_held_s2 <= long_held_d;
			three_s2     <= three_d;
			four_s2      <= multi_hold;
			sleep_s2     <= three_d & ~sleep_sent_q;
		end
	end

	assign out_valid       = valid_s2;
	assign begin_mask      = begin_s2;
	assign release_mask    = release_s2;
	assign holding_mask    = holding_s2;
	assign long_event_mask = long_ev_s2;
	assign long_held_mask  = long_held_s2;
	assign three_key_hold  = three_s2;
	assign four_key_hold   = four_s2;
	assign sleep_request   = sleep_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/tked_checker.sv =====
// Port-level checks for the touch key event decoder, bound to the top level.
// Depends on tked_pkg and touch_key_event_decoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "touch_key_event_decoder_macros.svh"

module tked_checker
	import tked_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [NUM_KEYS-1:0] begin_mask,
	input wire logic [NUM_KEYS-1:0] release_mask,
	input wire logic [NUM_KEYS-1:0] holding_mask,
	input wire logic [NUM_KEYS-1:0] long_event_mask,
	input wire logic [NUM_KEYS-1:0] long_held_mask,
	input wire logic                three_key_hold,
	input wire logic                sleep_request
);

	// a key cannot begin and release in the same beat, nor be holding while it begins or releases
	`TKED_ASSERT_IMP(a_key_events_disjoint, out_valid, ((begin_mask & release_mask) == '0) && ((begin_mask & holding_mask) == '0) && ((release_mask & holding_mask) == '0))

	// a firing long touch is reported as held and not as plain holding
	`TKED_ASSERT_IMP(a_long_event_held, out_valid, ((long_event_mask & ~long_held_mask) == '0) && ((long_event_mask & holding_mask) == '0))

	// sleep only on a three-key hold
	`TKED_ASSERT_IMP(a_sleep_needs_three, out_valid && sleep_request, three_key_hold)

	// stalled result beat holds
	`TKED_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(long_held_mask) && $stable(begin_mask) && $stable(sleep_request))

endmodule

bind touch_key_event_decoder tked_checker u_tked_checker (.*);

`default_nettype wire

// ===== test/touch_key_event_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for touch_key_event_decoder: directed key, gesture, threshold and time-wrap
// tests, then random touch sequences under several threshold settings with bursty input and
// output stalls. Depends on tked_pkg and the decoder RTL.

module touch_key_event_decoder_tb;
	import tked_pkg::*;

	localparam int QUIET_LIMIT       = 4000;
	localparam int RANDOM_PHASES     = 6;
	localparam int SAMPLES_PER_PHASE = 255;
	localparam int SETTLE_CYCLES     = 4;
	localparam int MAX_REPORTS       = 10;

	localparam int EVEN_SLOT  = 0;
	localparam int ODD_SLOT   = 1;
	localparam int MULTI_SLOT = 2;

	typedef struct packed {
		logic [NUM_KEYS-1:0] begin_mask;
		logic [NUM_KEYS-1:0] release_mask;
		logic [NUM_KEYS-1:0] holding_mask;
		logic [NUM_KEYS-1:0] long_event_mask;
		logic [NUM_KEYS-1:0] long_held_mask;
		logic                three_key_hold;
		logic                four_key_hold;
		logic                sleep_request;
	} sample_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [0:0]          cfg_index = CFG_LONG_TOUCH;
	logic [THR_W-1:0]    cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [NUM_KEYS-1:0] key_mask  = '0;
	logic [TIME_W-1:0]   now_ms    = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [NUM_KEYS-1:0] begin_mask;
	logic [NUM_KEYS-1:0] release_mask;
	logic [NUM_KEYS-1:0] holding_mask;
	logic [NUM_KEYS-1:0] long_event_mask;
	logic [NUM_KEYS-1:0] long_held_mask;
	logic                three_key_hold;
	logic                four_key_hold;
	logic                sleep_request;

	// predictor state and its copy of the thresholds
	logic [THR_W-1:0]    long_ms     = LONG_TOUCH_RST;
	logic [THR_W-1:0]    gest_ms     = GESTURE_HOLD_RST;
	logic [NUM_KEYS-1:0] last_keys   = '0;
	logic [NUM_KEYS-1:0] armed       = '0;
	logic [NUM_KEYS-1:0] in_long     = '0;
	logic [TIME_W-1:0]   touch_time [NUM_KEYS];
	logic [TIME_W-1:0]   pattern_since [3];
	logic [2:0]          pattern_run = '0;
	logic                sleep_given = 1'b0;

	sample_result_t expected_results [$];
	int fail_count   = 0;
	int samples_sent = 0;
	int burst_left   = 0;
	int quiet_cycles = 0;
	int rx_mode      = 0;
	int rx_left      = 0;
	int stall_left   = 0;

	touch_key_event_decoder DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_mask        (key_mask),
		.now_ms          (now_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.begin_mask      (begin_mask),
		.release_mask    (release_mask),
		.holding_mask    (holding_mask),
		.long_event_mask (long_event_mask),
		.long_held_mask  (long_held_mask),
		.three_key_hold  (three_key_hold),
		.four_key_hold   (four_key_hold),
		.sleep_request   (sleep_request)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic sample_result_t predict_sample(input logic [NUM_KEYS-1:0] keys,
			input logic [TIME_W-1:0] now);
		sample_result_t r;
		logic [TIME_W-1:0] elapsed;
		logic [2:0] active;
		logic [2:0] held;
		r = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (keys[i] && !last_keys[i]) begin
				touch_time[i] = now;
				armed[i] = 1'b1;
				r.begin_mask[i] = 1'b1;
			end else if (!keys[i] && last_keys[i]) begin
				r.release_mask[i] = 1'b1;
				in_long[i] = 1'b0;
			end else if (keys[i]) begin
				elapsed = now - touch_time[i];
				if (armed[i] && elapsed >= TIME_W'(long_ms)) begin
					r.long_event_mask[i] = 1'b1;
					in_long[i] = 1'b1;
					armed[i] = 1'b0;
				end else begin
					r.holding_mask[i] = 1'b1;
				end
			end
		end
		last_keys = keys;
		r.long_held_mask = in_long;

		active[EVEN_SLOT]  = (keys == EVEN_PATTERN);
		active[ODD_SLOT]   = (keys == ODD_PATTERN);
		active[MULTI_SLOT] = ($countones(keys) >= MULTI_MIN);
		for (int g = 0; g < 3; g++) begin
			held[g] = 1'b0;
			if (!active[g]) begin
				pattern_run[g] = 1'b0;
			end else begin
				if (!pattern_run[g]) begin
					pattern_since[g] = now;
					pattern_run[g] = 1'b1;
				end
				elapsed = now - pattern_since[g];
				held[g] = (elapsed >= TIME_W'(gest_ms));
			end
		end
		r.three_key_hold = held[EVEN_SLOT] | held[ODD_SLOT];
		r.four_key_hold  = held[MULTI_SLOT];
		// sleep fires once per rising edge of the three-key hold
		if (r.three_key_hold) begin
			if (!sleep_given) begin
				r.sleep_request = 1'b1;
				sleep_given = 1'b1;
			end
		end else begin
			sleep_given = 1'b0;
		end
		return r;
	endfunction

	function automatic string describe_result(input sample_result_t r);
		return $sformatf("beg=%h rel=%h hold=%h lev=%h lheld=%h three=%b four=%b sleep=%b",
			r.begin_mask, r.release_mask, r.holding_mask, r.long_event_mask,
			r.long_held_mask, r.three_key_hold, r.four_key_hold, r.sleep_request);
	endfunction

	function automatic logic [TIME_W-1:0] time_step(input int scale);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return '0;
		if (pick < 85)
			return $urandom_range(0, scale / 6 + 3);
		if (pick < 95)
			return $urandom_range(scale / 2, scale + scale / 4 + 2);
		return $urandom;
	endfunction

	// Called at a clock edge; returns at the edge where the beat is taken, valid still high.
	task automatic send_sample(input logic [NUM_KEYS-1:0] keys, input logic [TIME_W-1:0] stamp);
		in_valid <= 1'b1;
		key_mask <= keys;
		now_ms   <= stamp;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_sample(keys, stamp));
		samples_sent++;
	endtask

	task automatic feed(input logic [NUM_KEYS-1:0] keys, input logic [TIME_W-1:0] stamp);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0: gap = $urandom_range(8, 25);
				default: gap = $urandom_range(1, 4);
			endcase
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			case ($urandom_range(0, 3))
				0: burst_left = $urandom_range(40, 120);
				default: burst_left = $urandom_range(1, 8);
			endcase
		end
		burst_left--;
		send_sample(keys, stamp);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [THR_W-1:0] long_val, input logic [THR_W-1:0] gest_val);
		cfg_idx_t idx;
		logic [THR_W-1:0] val;
		wait_idle();
		for (int r = 0; r < 2; r++) begin
			idx = (r == 0) ? CFG_LONG_TOUCH : CFG_GESTURE_HOLD;
			val = (r == 0) ? long_val : gest_val;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			do @(posedge clk); while (!cfg_ready);
			if (idx == CFG_LONG_TOUCH)
				long_ms = val;
			else
				gest_ms = val;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_key_events();
		logic [TIME_W-1:0] t0;
		t0 = 32'h1000_0000;
		feed(6'h3f, t0);
		feed(6'h3f, t0 + 999);
		feed(6'h3f, t0 + 1000);
		feed(6'h3f, t0 + 2000);
		feed(6'h00, t0 + 2001);
		feed(6'h00, t0 + 2002);
		feed(6'h21, t0 + 2003);
		feed(6'h1e, t0 + 2200);
	endtask

	task automatic test_three_key_sleep();
		logic [TIME_W-1:0] t0;
		t0 = 32'h7000_0000;
		feed(EVEN_PATTERN, t0);
		feed(EVEN_PATTERN, t0 + 1999);
		feed(EVEN_PATTERN, t0 + 2000);
		feed(EVEN_PATTERN, t0 + 2500);
		feed(ODD_PATTERN, t0 + 2501);
		feed(ODD_PATTERN, t0 + 4501);
		feed(6'h00, t0 + 4502);
	endtask

	task automatic test_zero_thresholds();
		logic [TIME_W-1:0] t0;
		configure('0, '0);
		t0 = 32'h5555_aaaa;
		feed(ODD_PATTERN, t0);
		feed(ODD_PATTERN, t0);
		feed(6'h3f, t0 + 1);
		feed(6'h00, t0 + 2);
	endtask

	task automatic test_time_wrap();
		logic [TIME_W-1:0] t0;
		configure(LONG_TOUCH_RST, GESTURE_HOLD_RST);
		t0 = 32'hffff_fe00;
		feed(6'h0f, t0);
		feed(6'h0f, t0 + 999);
		feed(6'h0f, t0 + 1000);
		feed(6'h0f, t0 + 2000);
		feed(6'h00, 32'hffff_ffff);
		feed(6'h00, 32'h0000_0000);
	endtask

	// Mostly held patterns (gestures, multi-key, random) with flicker, plus random noise.
	task automatic test_random_traffic();
		logic [THR_W-1:0]    long_val;
		logic [THR_W-1:0]    gest_val;
		logic [TIME_W-1:0]   clock_ms;
		logic [NUM_KEYS-1:0] hold_keys;
		logic [NUM_KEYS-1:0] keys;
		int target;
		int scale;
		int hold_len;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					long_val = LONG_TOUCH_RST;
					gest_val = GESTURE_HOLD_RST;
				end
				1: begin
					long_val = '0;
					gest_val = '0;
				end
				2: begin
					long_val = '1;
					gest_val = '1;
				end
				3: begin
					long_val = '0;
					gest_val = '1;
				end
				4: begin
					long_val = '1;
					gest_val = '0;
				end
				default: begin
					long_val = THR_W'($urandom_range(0, 400));
					gest_val = THR_W'($urandom_range(0, 800));
				end
			endcase
			configure(long_val, gest_val);
			scale = int'((long_val > gest_val) ? long_val : gest_val);
			clock_ms = $urandom;
			target = samples_sent + SAMPLES_PER_PHASE;
			while (samples_sent < target) begin
				if ($urandom_range(0, 99) < 70) begin
					case ($urandom_range(0, 3))
						0: hold_keys = EVEN_PATTERN;
						1: hold_keys = ODD_PATTERN;
						2: begin
							hold_keys = NUM_KEYS'($urandom_range(0, 63));
							while ($countones(hold_keys) < MULTI_MIN)
								hold_keys[3'($urandom_range(0, NUM_KEYS - 1))] = 1'b1;
						end
						default: hold_keys = NUM_KEYS'($urandom_range(1, 63));
					endcase
					hold_len = $urandom_range(2, 12);
					for (int k = 0; k < hold_len; k++) begin
						keys = hold_keys;
						if ($urandom_range(0, 19) == 0)
							keys[3'($urandom_range(0, NUM_KEYS - 1))] ^= 1'b1;
						clock_ms += time_step(scale);
						feed(keys, clock_ms);
					end
					keys = ($urandom_range(0, 1) == 0) ? '0 :
						(hold_keys & NUM_KEYS'($urandom_range(0, 63)));
					clock_ms += time_step(scale);
					feed(keys, clock_ms);
				end else begin
					repeat ($urandom_range(1, 6)) begin
						clock_ms += time_step(scale);
						feed(NUM_KEYS'($urandom_range(0, 63)), clock_ms);
					end
				end
			end
		end
	endtask

	// output stall pattern: free-flowing, coin flip, fixed duty, or rare long stalls
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(60, 300);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			2: out_ready <= ((rx_left % 7) < 4);
			default: begin
				if (stall_left > 0)
					stall_left--;
				else if ($urandom_range(0, 15) == 0)
					stall_left = $urandom_range(5, 30);
				out_ready <= (stall_left == 0);
			end
		endcase
	end

	always @(posedge clk) begin : result_check
		sample_result_t got;
		sample_result_t want;
		logic [7:0] bad;
		if (arst_n && out_valid && out_ready) begin
			got = {begin_mask, release_mask, holding_mask, long_event_mask, long_held_mask,
				three_key_hold, four_key_hold, sleep_request};
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result beat with nothing expected: %s", $realtime,
						describe_result(got));
			end else begin
				want = expected_results.pop_front();
				bad = {got.begin_mask !== want.begin_mask,
					got.release_mask !== want.release_mask,
					got.holding_mask !== want.holding_mask,
					got.long_event_mask !== want.long_event_mask,
					got.long_held_mask !== want.long_held_mask,
					got.three_key_hold !== want.three_key_hold,
					got.four_key_hold !== want.four_key_hold,
					got.sleep_request !== want.sleep_request};
				if (bad != 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: mismatch (fields %b)\n  exp %s\n  got %s", $realtime, bad,
							describe_result(want), describe_result(got));
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_key_events();
		test_three_key_sleep();
		test_zero_thresholds();
		test_time_wrap();
		test_random_traffic();
		wait_idle();
		if (fail_count == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
